// ===== rtl/core/premul_rgba16_over_blend_core_assert.svh =====
// Assertion macros used by the checker of this core.
`ifndef PREMUL_RGBA16_OVER_BLEND_CORE_ASSERT_SVH
`define PREMUL_RGBA16_OVER_BLEND_CORE_ASSERT_SVH

// Checked only while out of reset.
`define POB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define POB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pob_pkg.sv =====
`timescale 1ns / 1ps

package pob_pkg;

  localparam int CHANNEL_BITS   = 16;
  localparam int COORD_BITS     = 12;
  localparam int DIM_BITS       = 13;
  localparam int OFFSET_BITS    = 16;
  localparam int MAX_DIM        = 4096;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [DIM_BITS-1:0]     dim_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_OFFSET_X        = 3'd0,
    CFG_OFFSET_Y        = 3'd1,
    CFG_DEST_WIDTH      = 3'd2,
    CFG_DEST_HEIGHT     = 3'd3,
    CFG_SOURCE_WIDTH    = 3'd4,
    CFG_SOURCE_HEIGHT   = 3'd5,
    CFG_TRANSPARENT_MAX = 3'd6,
    CFG_OPAQUE_MIN      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic signed [OFFSET_BITS-1:0] offset_x;
    logic signed [OFFSET_BITS-1:0] offset_y;
    dim_t                          dest_width;
    dim_t                          dest_height;
    dim_t                          source_width;
    dim_t                          source_height;
    chan_t                         transparent_max;
    chan_t                         opaque_min;
  } cfg_t;

  typedef struct packed {
    coord_t src_x;
    coord_t src_y;
    chan_t  src_red;
    chan_t  src_green;
    chan_t  src_blue;
    chan_t  src_alpha;
    chan_t  dst_red;
    chan_t  dst_green;
    chan_t  dst_blue;
    chan_t  dst_alpha;
  } in_item_t;

  typedef struct packed {
    logic   write_enable;
    coord_t target_x;
    coord_t target_y;
    chan_t  out_red;
    chan_t  out_green;
    chan_t  out_blue;
    chan_t  out_alpha;
  } out_item_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

  typedef struct packed {
    logic write_en;  // inside clip and not transparent
    logic blend;     // mix with destination, else plain copy
  } ctl_t;

  typedef struct packed {
    ctl_t   ctl;
    coord_t target_x;
    coord_t target_y;
    pixel_t src;
    pixel_t dst;
    chan_t  inv;
  } stage1_t;

  typedef struct packed {
    ctl_t   ctl;
    coord_t target_x;
    coord_t target_y;
    pixel_t src;
    pixel_t prod;
  } stage2_t;

  function automatic dim_t clamp_dim(input dim_t v);
    return (v > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : v;
  endfunction

endpackage

// ===== rtl/core/pob_stream_if.sv =====
`timescale 1ns / 1ps

interface pob_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pob_cfg_regs.sv =====
`timescale 1ns / 1ps

module pob_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pob_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pob_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output pob_pkg::cfg_t                        cfg
);

  // All zero except opaque_min, which comes up at full scale.
  localparam pob_pkg::cfg_t CFG_RESET = '{
    opaque_min: {pob_pkg::CHANNEL_BITS{1'b1}},
    default:    '0
  };

  pob_pkg::cfg_t cfg_r;
  pob_pkg::cfg_t cfg_nxt;
  pob_pkg::dim_t dim_val;

  assign dim_val = pob_pkg::clamp_dim(cfg_data[pob_pkg::DIM_BITS-1:0]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pob_pkg::CFG_OFFSET_X:        cfg_nxt.offset_x        = cfg_data;
        pob_pkg::CFG_OFFSET_Y:        cfg_nxt.offset_y        = cfg_data;
        pob_pkg::CFG_DEST_WIDTH:      cfg_nxt.dest_width      = dim_val;
        pob_pkg::CFG_DEST_HEIGHT:     cfg_nxt.dest_height     = dim_val;
        pob_pkg::CFG_SOURCE_WIDTH:    cfg_nxt.source_width    = dim_val;
        pob_pkg::CFG_SOURCE_HEIGHT:   cfg_nxt.source_height   = dim_val;
        pob_pkg::CFG_TRANSPARENT_MAX: cfg_nxt.transparent_max = cfg_data;
        pob_pkg::CFG_OPAQUE_MIN:      cfg_nxt.opaque_min      = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pob_clip_stage.sv =====
`timescale 1ns / 1ps

module pob_clip_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  pob_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  pob_pkg::in_item_t  in_item,
  output logic               in_ready,
  output logic               s1_valid,
  output pob_pkg::stage1_t   s1,
  input  logic               s1_ready
);

  localparam int TX_BITS = pob_pkg::OFFSET_BITS + 2;

  logic [TX_BITS-1:0] tx;
  logic [TX_BITS-1:0] ty;
  logic               in_clip;
  logic               transparent;
  pob_pkg::stage1_t   s1_nxt;
  pob_pkg::stage1_t   s1_r;
  logic               s1_valid_r;

  // Signed target position; top bit set means left of or above the canvas.
  assign tx = TX_BITS'({1'b0, in_item.src_x}) +
              {{2{cfg.offset_x[pob_pkg::OFFSET_BITS-1]}}, cfg.offset_x};
  assign ty = TX_BITS'({1'b0, in_item.src_y}) +
              {{2{cfg.offset_y[pob_pkg::OFFSET_BITS-1]}}, cfg.offset_y};

  assign in_clip = ({1'b0, in_item.src_x} < cfg.source_width) &&
                   ({1'b0, in_item.src_y} < cfg.source_height) &&
                   !tx[TX_BITS-1] && !ty[TX_BITS-1] &&
                   (tx[TX_BITS-2:0] < (TX_BITS-1)'(cfg.dest_width)) &&
                   (ty[TX_BITS-2:0] < (TX_BITS-1)'(cfg.dest_height));

  assign transparent = in_item.src_alpha <= cfg.transparent_max;

  always_comb begin
    s1_nxt.ctl.write_en = in_clip && !transparent;
    s1_nxt.ctl.blend    = (in_item.src_alpha < cfg.opaque_min) && (in_item.dst_alpha != '0);
    s1_nxt.target_x     = tx[pob_pkg::COORD_BITS-1:0];
    s1_nxt.target_y     = ty[pob_pkg::COORD_BITS-1:0];
    s1_nxt.src.red      = in_item.src_red;
    s1_nxt.src.green    = in_item.src_green;
    s1_nxt.src.blue     = in_item.src_blue;
    s1_nxt.src.alpha    = in_item.src_alpha;
    s1_nxt.dst.red      = in_item.dst_red;
    s1_nxt.dst.green    = in_item.dst_green;
    s1_nxt.dst.blue     = in_item.dst_blue;
    s1_nxt.dst.alpha    = in_item.dst_alpha;
    s1_nxt.inv          = ~in_item.src_alpha;  // full scale minus alpha
  end

  assign in_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== rtl/core/pob_blend_pipe.sv =====
`timescale 1ns / 1ps

module pob_blend_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  pob_pkg::stage1_t    s1,
  output logic                s1_ready,
  output logic                out_valid,
  output pob_pkg::out_item_t  out_item,
  input  logic                out_ready
);

  localparam int PROD_BITS = 2 * pob_pkg::CHANNEL_BITS;

  pob_pkg::stage2_t   s2_nxt;
  pob_pkg::stage2_t   s2_r;
  logic               s2_valid_r;
  logic               s2_ready;
  pob_pkg::out_item_t out_nxt;
  pob_pkg::out_item_t out_r;
  logic               out_valid_r;
  pob_pkg::pixel_t    mixed;

  function automatic pob_pkg::chan_t mul_hi(input pob_pkg::chan_t d, input pob_pkg::chan_t inv);
    logic [PROD_BITS-1:0] p;
    p = PROD_BITS'(d) * PROD_BITS'(inv);
    return p[PROD_BITS-1:pob_pkg::CHANNEL_BITS];
  endfunction

  // Multiply stage.
  always_comb begin
    s2_nxt.ctl        = s1.ctl;
    s2_nxt.target_x   = s1.target_x;
    s2_nxt.target_y   = s1.target_y;
    s2_nxt.src        = s1.src;
    s2_nxt.prod.red   = mul_hi(s1.dst.red, s1.inv);
    s2_nxt.prod.green = mul_hi(s1.dst.green, s1.inv);
    s2_nxt.prod.blue  = mul_hi(s1.dst.blue, s1.inv);
    s2_nxt.prod.alpha = mul_hi(s1.dst.alpha, s1.inv);
  end

  assign s1_ready = !s2_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_r <= s2_nxt;
    end
  end

  // Add and select stage; sums wrap to the channel width.
  always_comb begin
    mixed.red   = s2_r.src.red   + s2_r.prod.red;
    mixed.green = s2_r.src.green + s2_r.prod.green;
    mixed.blue  = s2_r.src.blue  + s2_r.prod.blue;
    mixed.alpha = s2_r.src.alpha + s2_r.prod.alpha;
    if (!s2_r.ctl.blend) begin
      mixed = s2_r.src;
    end
    out_nxt = '0;
    if (s2_r.ctl.write_en) begin
      out_nxt.write_enable = 1'b1;
      out_nxt.target_x     = s2_r.target_x;
      out_nxt.target_y     = s2_r.target_y;
      out_nxt.out_red      = mixed.red;
      out_nxt.out_green    = mixed.green;
      out_nxt.out_blue     = mixed.blue;
      out_nxt.out_alpha    = mixed.alpha;
    end
  end

  assign s2_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/premul_rgba16_over_blend_core.sv =====
`timescale 1ns / 1ps

// Source-over compositing of one premultiplied RGBA pixel (16 bits per channel)
// per clock unless the output stalls. Each input word carries a source pixel,
// its position and the destination pixel it lands on; each output word tells
// whether that destination is written, where, and with what color. The core
// takes a new word every cycle while input ready is high, and passes it through
// a clip/classify stage, a multiply stage and an add/select output register,
// each with its own valid bit. Input ready drops only when all three stages
// hold a word and the output is not taken. Configuration writes apply to
// words accepted after the write; write them while the core is empty.
// Width and height take the low 13 data bits; above 4096 they read as 4096.
module premul_rgba16_over_blend_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pob_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pob_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  pob_stream_if.sink                          in_ch,
  pob_stream_if.source                        out_ch
);

  pob_pkg::cfg_t      cfg;
  pob_pkg::in_item_t  in_item;
  pob_pkg::stage1_t   s1;
  logic               s1_valid;
  logic               s1_ready;
  pob_pkg::out_item_t out_item;

  assign in_item = in_ch.payload;

  pob_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pob_clip_stage u_clip_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  pob_blend_pipe u_blend_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .out_ready (out_ch.ready)
  );

  assign out_ch.payload = out_item;

endmodule

// ===== rtl/core/pob_port_checker.sv =====
`timescale 1ns / 1ps
`include "premul_rgba16_over_blend_core_assert.svh"

module pob_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pob_pkg::out_item_t out_payload
);

  `POB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_payload), "result word changed while stalled")
  `POB_ASSERT(a_skip_zero, clk, rst_n, out_valid && !out_payload.write_enable |-> out_payload == '0, "skipped pixel carries nonzero fields")
  `POB_ASSERT(a_alpha_nonzero, clk, rst_n, out_valid && out_payload.write_enable |-> out_payload.out_alpha != '0, "written pixel has zero alpha")
  `POB_ASSERT(a_backpressure, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled while output drains")
  `POB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind premul_rgba16_over_blend_core pob_port_checker u_pob_port_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
